/* sv/iterated_hash_random_generator_macros.svh */
// Assertion macros for the iterated hash random generator.
// Used by the RTL files that carry concurrent assertions; no dependencies.
`ifndef ITERATED_HASH_RANDOM_GENERATOR_MACROS_SVH
`define ITERATED_HASH_RANDOM_GENERATOR_MACROS_SVH

`ifndef SYNTH
`define IHRG_ASSERT_IMPLIES(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
        else $error("implication check failed");
`define IHRG_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
        else $error("next-cycle check failed");
`else
`define IHRG_ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define IHRG_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif

`endif

/* sv/ihrg_pkg.sv */
// Shared types and constants for the iterated hash random generator.
// No dependencies; imported by every module of the block.
package ihrg_pkg;

    localparam int unsigned WORD_W = 32;

    localparam logic [WORD_W-1:0] HASH_MUL_A = 32'd747796405;
    localparam logic [WORD_W-1:0] HASH_ADD_A = 32'd2891336453;
    localparam int unsigned       HASH_SEL   = 28;
    localparam logic [4:0]        HASH_BIAS  = 5'd4;
    localparam logic [WORD_W-1:0] HASH_MUL_B = 32'd277803737;
    localparam int unsigned       HASH_FOLD  = 22;

    localparam logic [WORD_W-1:0] SEED_RESET = '0;

    typedef enum logic [1:0] {
        OP_RESET  = 2'd0,
        OP_RAW    = 2'd1,
        OP_URANGE = 2'd2,
        OP_SRANGE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_HASH,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        HS_MUL_A,
        HS_MIX,
        HS_MUL_B,
        HS_FOLD
    } hash_step_t;

    typedef struct packed {
        op_t               operation;
        logic [WORD_W-1:0] range_min;
        logic [WORD_W-1:0] range_max;
    } in_t;

    typedef struct packed {
        logic [WORD_W-1:0] value;
        logic              range_error;
    } out_t;

endpackage

/* sv/ihrg_hash.sv */
// Multi-cycle PCG hash built around one shared 32x32 multiplier.
// Depends on ihrg_pkg for the hash constants and step codes.
module ihrg_hash
    import ihrg_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [WORD_W-1:0] x,
    output logic              done,
    output logic [WORD_W-1:0] result
);

    logic              busy_reg, busy_next;
    hash_step_t        step_reg, step_next;
    logic              done_reg, done_next;
    logic [WORD_W-1:0] prod_reg, prod_next;
    logic [WORD_W-1:0] mix_reg, mix_next;
    logic [WORD_W-1:0] result_reg, result_next;

    logic [WORD_W-1:0] mul_a, mul_b, mul_p;
    logic [WORD_W-1:0] sum;
    logic [4:0]        shamt;

    assign mul_a = busy_reg ? mix_reg : x;
    assign mul_b = busy_reg ? HASH_MUL_B : HASH_MUL_A;
    assign mul_p = WORD_W'(mul_a * mul_b);
    assign sum   = prod_reg + HASH_ADD_A;
    assign shamt = {1'b0, sum[WORD_W-1:HASH_SEL]} + HASH_BIAS;

    always_comb begin
        busy_next   = busy_reg;
        step_next   = step_reg;
        done_next   = 1'b0;
        prod_next   = prod_reg;
        mix_next    = mix_reg;
        result_next = result_reg;
        if (!busy_reg) begin
            if (start) begin
                prod_next = mul_p;
                step_next = HS_MIX;
                busy_next = 1'b1;
            end
        end else begin
            case (step_reg)
                HS_MIX: begin
                    mix_next  = (sum >> shamt) ^ sum;
                    step_next = HS_MUL_B;
                end
                HS_MUL_B: begin
                    prod_next = mul_p;
                    step_next = HS_FOLD;
                end
                HS_FOLD: begin
                    result_next = (prod_reg >> HASH_FOLD) ^ prod_reg;
                    done_next   = 1'b1;
                    busy_next   = 1'b0;
                    step_next   = HS_MUL_A;
                end
                default: begin
                    busy_next = 1'b0;
                    step_next = HS_MUL_A;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= HS_MUL_A;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            step_reg <= step_next;
            done_reg <= done_next;
        end
        prod_reg   <= prod_next;
        mix_reg    <= mix_next;
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

/* sv/ihrg_div.sv */
// Radix-2 restoring divider that yields the unsigned remainder, one bit per cycle.
// Depends on ihrg_pkg for the word width.
module ihrg_div
    import ihrg_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [WORD_W-1:0] dividend,
    input  logic [WORD_W-1:0] divisor,
    output logic              done,
    output logic [WORD_W-1:0] remainder
);

    localparam int unsigned CNT_W = $clog2(WORD_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WORD_W - 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [WORD_W-1:0] rem_reg, rem_next;
    logic [WORD_W-1:0] quo_reg, quo_next;
    logic [WORD_W-1:0] div_reg, div_next;

    logic [WORD_W:0]   trial;
    logic [WORD_W:0]   diff;

    assign trial = {rem_reg, quo_reg[WORD_W-1]};
    assign diff  = trial - {1'b0, div_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        if (!busy_reg) begin
            if (start) begin
                busy_next = 1'b1;
                cnt_next  = '0;
                rem_next  = '0;
                quo_next  = dividend;
                div_next  = divisor;
            end
        end else begin
            rem_next = diff[WORD_W] ? trial[WORD_W-1:0] : diff[WORD_W-1:0];
            quo_next = {quo_reg[WORD_W-2:0], 1'b0};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_LAST) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

/* sv/iterated_hash_random_generator.sv */
// Top level of the iterated hash random generator: sequencer, state and seed.
// Depends on ihrg_pkg, ihrg_hash, ihrg_div and the assertion macro header.
//
// Requests arrive on the s_ channel (valid/ready) as an in_t; results leave on
// the m_ channel (valid/ready) as an out_t, exactly one result per request.
// The seed register is written through cfg_wr_en/cfg_wr_data; the user must
// write it only while the block is idle, which the block itself does not enforce.
// A reset request loads the seed into the state.
// One request is worked on at a time, so s_ready is low from acceptance
// until the result has been moved into the output register.
// The hash runs four steps (multiply, mix, multiply, fold), two of them on the
// shared multiplier; a range draw then loads the restoring divider and runs
// its 32 iterations, while a raw draw or a zero-width range skips the divider.
// Reset sets the state word and the seed to SEED_INIT and empties the output.
// When the receiver stalls the result holds in the output register; the next
// request is still accepted and worked on, and its result waits inside the
// block until the output register is free.
`include "iterated_hash_random_generator_macros.svh"

module iterated_hash_random_generator
    import ihrg_pkg::*;
#(
    parameter logic [WORD_W-1:0] SEED_INIT = SEED_RESET
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [WORD_W-1:0] cfg_wr_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  in_t               s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output out_t              m_data
);

    state_t            state_reg, state_next;
    logic [WORD_W-1:0] seed_reg;
    logic [WORD_W-1:0] cur_reg, cur_next;
    in_t               req_reg, req_next;
    out_t              res_reg, res_next;
    logic              m_valid_reg, m_valid_next;
    out_t              m_data_reg, m_data_next;

    logic              accept;
    logic              hash_start, hash_done;
    logic [WORD_W-1:0] hash_res;
    logic              div_start, div_done;
    logic [WORD_W-1:0] div_dividend, div_divisor, div_rem;
    logic [WORD_W-1:0] width;
    logic [WORD_W-1:0] rem_signed;

    assign s_ready    = (state_reg == ST_IDLE);
    assign accept     = s_valid && s_ready;
    assign hash_start = accept && (s_data.operation != OP_RESET);
    assign width      = req_reg.range_max - req_reg.range_min;

    always_comb begin
        if (req_reg.operation == OP_SRANGE) begin
            div_dividend = hash_res[WORD_W-1] ? (~hash_res + WORD_W'(1)) : hash_res;
            div_divisor  = width[WORD_W-1] ? (~width + WORD_W'(1)) : width;
        end else begin
            div_dividend = hash_res;
            div_divisor  = width;
        end
    end

    assign rem_signed = (req_reg.operation == OP_SRANGE && cur_reg[WORD_W-1])
                        ? (~div_rem + WORD_W'(1)) : div_rem;

    always_comb begin
        state_next   = state_reg;
        cur_next     = cur_reg;
        req_next     = req_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        div_start    = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    req_next = s_data;
                    if (s_data.operation == OP_RESET) begin
                        cur_next   = seed_reg;
                        res_next   = '{value: seed_reg, range_error: 1'b0};
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_HASH;
                    end
                end
            end
            ST_HASH: begin
                if (hash_done) begin
                    cur_next = hash_res;
                    if (req_reg.operation == OP_RAW) begin
                        res_next   = '{value: hash_res, range_error: 1'b0};
                        state_next = ST_DONE;
                    end else if (width == '0) begin
                        res_next   = '{value: req_reg.range_min, range_error: 1'b1};
                        state_next = ST_DONE;
                    end else begin
                        div_start  = 1'b1;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    res_next   = '{value: rem_signed + req_reg.range_min,
                                   range_error: 1'b0};
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            seed_reg    <= SEED_INIT;
            cur_reg     <= SEED_INIT;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cur_reg     <= cur_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                seed_reg <= cfg_wr_data;
            end
        end
        req_reg    <= req_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    ihrg_hash u_hash (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (hash_start),
        .x       (cur_reg),
        .done    (hash_done),
        .result  (hash_res)
    );

    ihrg_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .remainder (div_rem)
    );

    `IHRG_ASSERT_IMPLIES(a_hash_done_in_hash, aclk, aresetn, hash_done, state_reg == ST_HASH)
    `IHRG_ASSERT_IMPLIES(a_div_done_in_div, aclk, aresetn, div_done, state_reg == ST_DIV)
    `IHRG_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, accept, !s_ready)
    `IHRG_ASSERT_NEXT(a_load_after_done, aclk, aresetn, state_reg == ST_DONE && state_next == ST_IDLE, m_valid)

endmodule

/* sim/iterated_hash_random_generator_tb.sv */
// Self-checking testbench for iterated_hash_random_generator: random and directed draw requests
// are checked against an internal predictor of the PCG hash state and range arithmetic.
// Depends on ihrg_pkg and the RTL of the block; needs no files or arguments.
module iterated_hash_random_generator_tb;
    import ihrg_pkg::*;

    localparam int unsigned LIMIT_CYCLES = 1_000_000;
    localparam int unsigned PHASE_ITEMS  = 210;
    localparam int unsigned HOLD_CYCLES  = 400;

    logic              aclk        = 1'b0;
    logic              aresetn     = 1'b0;
    logic              cfg_wr_en   = 1'b0;
    logic [WORD_W-1:0] cfg_wr_data = '0;
    logic              s_valid     = 1'b0;
    logic              s_ready;
    in_t               s_data      = '0;
    logic              m_valid;
    logic              m_ready     = 1'b0;
    out_t              m_data;

    in_t               requests_todo[$];
    out_t              draws_due[$];
    logic [WORD_W-1:0] gen_state = SEED_RESET;
    logic [WORD_W-1:0] seed_reg  = SEED_RESET;
    bit                steady    = 1'b0;
    int unsigned       mismatches   = 0;
    int unsigned       results_seen = 0;
    int unsigned       hold_left    = 0;
    int unsigned       cycles       = 0;

    iterated_hash_random_generator dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic logic [WORD_W-1:0] pcg_scramble(logic [WORD_W-1:0] x);
        logic [WORD_W-1:0] s;
        logic [WORD_W-1:0] w;
        int unsigned       sh;
        s  = x * HASH_MUL_A + HASH_ADD_A;
        sh = (s >> HASH_SEL) + HASH_BIAS;
        w  = ((s >> sh) ^ s) * HASH_MUL_B;
        return (w >> HASH_FOLD) ^ w;
    endfunction

    function automatic logic [WORD_W-1:0] odd_inverse(logic [WORD_W-1:0] a);
        logic [WORD_W-1:0] inv;
        inv = a;
        repeat (5) inv = inv * (32'd2 - a * inv);
        return inv;
    endfunction

    // Seed whose scrambled value is y, so a chosen state is reached by the first draw after a reset request.
    function automatic logic [WORD_W-1:0] scramble_preimage(logic [WORD_W-1:0] y);
        logic [WORD_W-1:0] t;
        logic [WORD_W-1:0] s;
        int unsigned       sh;
        t  = (y ^ (y >> HASH_FOLD)) * odd_inverse(HASH_MUL_B);
        sh = (t >> HASH_SEL) + HASH_BIAS;
        s  = t;
        repeat (32) s = t ^ (s >> sh);
        return (s - HASH_ADD_A) * odd_inverse(HASH_MUL_A);
    endfunction

    function automatic logic [WORD_W-1:0] trunc_rem(logic [WORD_W-1:0] a, logic [WORD_W-1:0] d);
        logic [WORD_W-1:0] amag;
        logic [WORD_W-1:0] dmag;
        logic [WORD_W-1:0] r;
        amag = a[WORD_W-1] ? -a : a;
        dmag = d[WORD_W-1] ? -d : d;
        r    = amag % dmag;
        return a[WORD_W-1] ? -r : r;
    endfunction

    function automatic out_t predict_draw(in_t req);
        out_t              res;
        logic [WORD_W-1:0] width;
        res.range_error = 1'b0;
        if (req.operation == OP_RESET) begin
            gen_state = seed_reg;
            res.value = seed_reg;
        end else begin
            gen_state = pcg_scramble(gen_state);
            width     = req.range_max - req.range_min;
            if (req.operation == OP_RAW) begin
                res.value = gen_state;
            end else if (width == '0) begin
                res.value       = req.range_min;
                res.range_error = 1'b1;
            end else if (req.operation == OP_URANGE) begin
                res.value = gen_state % width + req.range_min;
            end else begin
                res.value = trunc_rem(gen_state, width) + req.range_min;
            end
        end
        return res;
    endfunction

    function automatic void queue_request(op_t op, logic [WORD_W-1:0] lo, logic [WORD_W-1:0] hi);
        in_t req;
        req.operation = op;
        req.range_min = lo;
        req.range_max = hi;
        requests_todo.push_back(req);
    endfunction

    function automatic logic [WORD_W-1:0] pick_corner();
        case ($urandom_range(0, 5))
            0: return 32'h0000_0000;
            1: return 32'h0000_0001;
            2: return 32'h7FFF_FFFF;
            3: return 32'h8000_0000;
            4: return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    function automatic void queue_random_request();
        op_t               op;
        logic [WORD_W-1:0] lo;
        logic [WORD_W-1:0] hi;
        if ($urandom_range(0, 99) < 8) begin
            op = OP_RESET;
        end else begin
            op = op_t'($urandom_range(1, 3));
        end
        lo = $urandom();
        case ($urandom_range(0, 5))
            0: hi = $urandom();
            1: hi = lo + $urandom_range(1, 1000);
            2: hi = lo;
            3: begin
                lo = -$urandom_range(0, 1000);
                hi = $urandom_range(0, 1000);
            end
            4: hi = lo - $urandom_range(1, 1000);
            default: begin
                lo = pick_corner();
                hi = pick_corner();
            end
        endcase
        queue_request(op, lo, hi);
    endfunction

    task automatic drain();
        while (requests_todo.size() != 0 || s_valid || draws_due.size() != 0)
            @(negedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_seed(logic [WORD_W-1:0] v);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        seed_reg = v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        write_seed(32'h0000_0000);

        queue_request(OP_RAW, 32'h0, 32'h0);
        queue_request(OP_URANGE, 32'd0, 32'd10);
        queue_request(OP_SRANGE, -32'd10, 32'd10);
        queue_request(OP_RESET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_request(OP_URANGE, 32'h0, 32'h0);
        queue_request(OP_SRANGE, 32'h8000_0000, 32'h8000_0000);
        queue_request(OP_URANGE, 32'h0, 32'hFFFF_FFFF);
        queue_request(OP_URANGE, 32'hFFFF_FFFF, 32'h0);
        queue_request(OP_URANGE, 32'd100, 32'd10);
        queue_request(OP_SRANGE, 32'h7FFF_FFFF, 32'h8000_0000);
        queue_request(OP_SRANGE, 32'h8000_0000, 32'h7FFF_FFFF);
        queue_request(OP_SRANGE, 32'h0, 32'h8000_0000);
        queue_request(OP_SRANGE, 32'h1, 32'h0);
        queue_request(OP_RAW, 32'hFFFF_FFFF, 32'h0);
        queue_request(OP_SRANGE, 32'hFFFF_FFFF, 32'hFFFF_FFF0);
        drain();

        // Reach the most negative state so that a divisor of minus one meets it.
        write_seed(scramble_preimage(32'h8000_0000));
        queue_request(OP_RESET, 32'h0, 32'h0);
        queue_request(OP_SRANGE, 32'h0, 32'hFFFF_FFFF);
        queue_request(OP_RESET, 32'h0, 32'h0);
        queue_request(OP_SRANGE, 32'h0, 32'h8000_0000);
        queue_request(OP_RESET, 32'h0, 32'h0);
        queue_request(OP_URANGE, 32'h0, 32'h3);
        drain();

        for (int p = 0; p < 8; p++) begin
            case (p)
                0: write_seed(32'hFFFF_FFFF);
                1: write_seed(32'h0000_0000);
                2: write_seed(32'h8000_0000);
                3: write_seed(scramble_preimage(32'h7FFF_FFFF));
                default: write_seed($urandom());
            endcase
            steady = (p == 3);
            queue_request(OP_RESET, 32'h0, 32'h0);
            for (int i = 0; i < PHASE_ITEMS; i++)
                queue_random_request();
            drain();
        end
        steady = 1'b0;

        repeat (50) @(posedge aclk);
        if (mismatches == 0 && draws_due.size() == 0) begin
            $display("iterated_hash_random_generator: match");
        end else begin
            $display("iterated_hash_random_generator: mismatch");
        end
        $finish;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (s_valid)
                draws_due.push_back(predict_draw(s_data));
            if (requests_todo.size() != 0 && (steady || $urandom_range(0, 99) >= 14)) begin
                s_valid <= 1'b1;
                s_data  <= requests_todo.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        out_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (results_seen == 300 || results_seen == 1200)
                    hold_left = HOLD_CYCLES;
                if (draws_due.size() == 0) begin
                    if (mismatches < 10)
                        $display("unexpected result: value %h range_error %b",
                                 m_data.value, m_data.range_error);
                    mismatches++;
                end else begin
                    want = draws_due.pop_front();
                    if (m_data.value !== want.value
                            || m_data.range_error !== want.range_error) begin
                        if (mismatches < 10)
                            $display("result %0d: expected value %h range_error %b, got %h %b",
                                     results_seen, want.value, want.range_error,
                                     m_data.value, m_data.range_error);
                        mismatches++;
                    end
                end
            end
            if (hold_left != 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= steady || $urandom_range(0, 99) >= 14;
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= LIMIT_CYCLES) begin
            $display("iterated_hash_random_generator: mismatch");
            $finish;
        end
    end

endmodule
